// ----- rtl/assert_macros.svh -----
// Assertion helpers used by the top level of the atan2 core.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// ante implies cons on the same clock edge
`define AST_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion violated");

// expr must never hold
`define AST_NEVER(label, clk, rst_n, expr) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
		else $error("assertion violated");

`endif

// ----- rtl/fa2d_pkg.sv -----
// Shared types and fixed constants of the atan2 core.
// No dependencies.
`timescale 1ns / 1ps

package fa2d_pkg;

	localparam int Q_FRAC  = 16;
	localparam int RATIO_W = Q_FRAC + 1;
	localparam int COEF_W  = 24;

	localparam logic [RATIO_W-1:0] RATIO_ONE = RATIO_W'(1 << Q_FRAC);

	localparam logic signed [COEF_W-1:0] COEF_P1 = 24'sd3754140;
	localparam logic signed [COEF_W-1:0] COEF_P3 = -24'sd1223390;
	localparam logic signed [COEF_W-1:0] COEF_P5 = 24'sd584188;
	localparam logic signed [COEF_W-1:0] COEF_P7 = -24'sd166443;

	typedef struct packed {
		logic steep;
		logic neg_x;
		logic neg_y;
	} octant_t;

endpackage

// ----- rtl/fa2d_div.sv -----
// Pipelined restoring divider: ratio = floor(mn * 2^16 / mx), one quotient bit per stage.
// Depends on fa2d_pkg.
`timescale 1ns / 1ps

module fa2d_div import fa2d_pkg::*; #(
	parameter int IN_WIDTH = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  logic                vld_in,
	input  logic [IN_WIDTH-1:0] mn,
	input  logic [IN_WIDTH-1:0] mx,
	input  octant_t             oct_in,
	output logic                vld_out,
	output logic [RATIO_W-1:0]  ratio,
	output octant_t             oct_out
);

	localparam int RW    = IN_WIDTH + 1;
	localparam int STEPS = RATIO_W;

	logic [RW-1:0]       rem_s  [1:STEPS];
	logic [IN_WIDTH-1:0] dvs_s  [1:STEPS];
	logic [RATIO_W-1:0]  quo_s  [1:STEPS];
	logic                zero_s [1:STEPS];
	logic                vld_s  [1:STEPS];
	octant_t             oct_s  [1:STEPS];

	for (genvar k = 1; k <= STEPS; k++) begin : g_step
		logic [RW-1:0]       r_in;
		logic [RATIO_W-1:0]  q_in;
		logic [IN_WIDTH-1:0] d_in;
		logic                z_in;
		logic                v_in;
		octant_t             o_in;
		logic                ge;

		if (k == 1) begin : g_first
			assign r_in = {1'b0, mn};
			assign q_in = '0;
			assign d_in = mx;
			assign z_in = (mx == '0);
			assign v_in = vld_in;
			assign o_in = oct_in;
		end else begin : g_next
			assign r_in = {rem_s[k-1][RW-2:0], 1'b0};
			assign q_in = quo_s[k-1];
			assign d_in = dvs_s[k-1];
			assign z_in = zero_s[k-1];
			assign v_in = vld_s[k-1];
			assign o_in = oct_s[k-1];
		end

		assign ge = (r_in >= {1'b0, d_in});

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else if (en) begin
				vld_s[k] <= v_in;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k]  <= ge ? (r_in - {1'b0, d_in}) : r_in;
				quo_s[k]  <= {q_in[RATIO_W-2:0], ge};
				dvs_s[k]  <= d_in;
				zero_s[k] <= z_in;
				oct_s[k]  <= o_in;
			end
		end
	end

	assign vld_out = vld_s[STEPS];
	assign ratio   = zero_s[STEPS] ? '0 : quo_s[STEPS];
	assign oct_out = oct_s[STEPS];

endmodule

// ----- rtl/fa2d_poly.sv -----
// Odd 7th-order polynomial in the ratio, one multiply per stage but the last, which rounds to the output format.
// Depends on fa2d_pkg.
`timescale 1ns / 1ps

module fa2d_poly import fa2d_pkg::*; #(
	parameter int ANGLE_FRAC_BITS = 8
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       en,
	input  logic                       vld_in,
	input  logic [RATIO_W-1:0]         ratio,
	input  octant_t                    oct_in,
	output logic                       vld_out,
	output logic [ANGLE_FRAC_BITS+8:0] oct_angle,
	output octant_t                    oct_out
);

	localparam int OW = ANGLE_FRAC_BITS + 9;
	localparam int SH = Q_FRAC - ANGLE_FRAC_BITS;
	localparam int PW = COEF_W + RATIO_W + 1;

	localparam logic signed [PW-1:0]      HALF_S = PW'(1 << (Q_FRAC - 1));
	localparam logic [2*RATIO_W-1:0]      HALF_U = (2*RATIO_W)'(1 << (Q_FRAC - 1));

	function automatic logic signed [COEF_W-1:0] mul_q16(
		input logic signed [COEF_W-1:0] a,
		input logic        [RATIO_W-1:0] b
	);
		logic signed [PW-1:0] p;
		p = a * $signed({1'b0, b}) + HALF_S;
		return p[Q_FRAC+COEF_W-1:Q_FRAC];
	endfunction

	logic [2*RATIO_W-1:0] sq;

	logic                     vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6;
	logic [RATIO_W-1:0]       c_s1, c_s2, c_s3, c_s4;
	logic [RATIO_W-1:0]       c2_s1, c2_s2, c2_s3;
	logic signed [COEF_W-1:0] t_s2, t_s3, t_s4;
	logic [COEF_W-2:0]        a16_s5;
	logic [OW-1:0]            a_s6;
	octant_t                  oct_s1, oct_s2, oct_s3, oct_s4, oct_s5, oct_s6;

	logic signed [COEF_W-1:0] a16_full;
	logic [OW-1:0]            a_rnd;

	assign sq       = ratio * ratio + HALF_U;
	assign a16_full = mul_q16(t_s4, c_s4);

	if (SH > 0) begin : g_round
		logic [COEF_W-1:0] sum;
		assign sum   = {1'b0, a16_s5} + COEF_W'(1 << (SH - 1));
		assign a_rnd = OW'(sum >> SH);
	end else begin : g_pass
		assign a_rnd = OW'(a16_s5);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
		end else if (en) begin
			vld_s1 <= vld_in;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			c_s1   <= ratio;
			c2_s1  <= sq[Q_FRAC+RATIO_W-1:Q_FRAC];
			oct_s1 <= oct_in;

			c_s2   <= c_s1;
			c2_s2  <= c2_s1;
			t_s2   <= mul_q16(COEF_P7, c2_s1) + COEF_P5;
			oct_s2 <= oct_s1;

			c_s3   <= c_s2;
			c2_s3  <= c2_s2;
			t_s3   <= mul_q16(t_s2, c2_s2) + COEF_P3;
			oct_s3 <= oct_s2;

			c_s4   <= c_s3;
			t_s4   <= mul_q16(t_s3, c2_s3) + COEF_P1;
			oct_s4 <= oct_s3;

			a16_s5 <= a16_full[COEF_W-1] ? '0 : a16_full[COEF_W-2:0];
			oct_s5 <= oct_s4;

			a_s6   <= a_rnd;
			oct_s6 <= oct_s5;
		end
	end

	assign vld_out   = vld_s6;
	assign oct_angle = a_s6;
	assign oct_out   = oct_s6;

endmodule

// ----- rtl/fast_atan2_degrees_core.sv -----
// Top level of the atan2 core: octant folding, divider, polynomial and unfolding.
// Depends on fa2d_pkg, fa2d_div, fa2d_poly and assert_macros.svh.
//
// Four-quadrant arctangent in degrees. Takes a signed vector (delta_y, delta_x)
// and returns its angle counter-clockwise from +x as an unsigned number with
// ANGLE_FRAC_BITS fractional bits, 0 to 360 inclusive; a zero vector gives 0.
// One beat is accepted every cycle while req_stall is low. The pipeline is one folding
// stage, 17 divider stages (one quotient bit each for the Q1.16 ratio), six polynomial
// stages (a multiply in each but the last) and the output register. When the output beat is
// stalled the whole pipeline holds; req_stall is high exactly then.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module fast_atan2_degrees_core import fa2d_pkg::*; #(
	parameter int IN_WIDTH        = 16,
	parameter int ANGLE_FRAC_BITS = 8
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              req_valid,
	output logic                              req_stall,
	input  logic signed [IN_WIDTH-1:0]        delta_y,
	input  logic signed [IN_WIDTH-1:0]        delta_x,
	output logic                              rsp_valid,
	input  logic                              rsp_stall,
	output logic        [ANGLE_FRAC_BITS+8:0] angle
);

	localparam int OW = ANGLE_FRAC_BITS + 9;

	localparam logic [OW-1:0] DEG90  = OW'(90 << ANGLE_FRAC_BITS);
	localparam logic [OW-1:0] DEG180 = OW'(180 << ANGLE_FRAC_BITS);
	localparam logic [OW-1:0] DEG360 = OW'(360 << ANGLE_FRAC_BITS);

	logic en;

	logic [IN_WIDTH-1:0] ax, ay;
	octant_t             oct_in;

	logic                vld_s1;
	logic [IN_WIDTH-1:0] mn_s1, mx_s1;
	octant_t             oct_s1;

	logic               div_vld;
	logic [RATIO_W-1:0] div_c;
	octant_t            div_oct;

	logic          poly_vld;
	logic [OW-1:0] poly_a;
	octant_t       poly_oct;

	logic [OW-1:0] u_steep, u_negx, u_negy;

	logic          rsp_valid_q;
	logic [OW-1:0] angle_q;

	assign en        = !rsp_valid_q || !rsp_stall;
	assign req_stall = !en;

	assign ay = delta_y[IN_WIDTH-1] ? ($unsigned(~delta_y) + 1'b1) : $unsigned(delta_y);
	assign ax = delta_x[IN_WIDTH-1] ? ($unsigned(~delta_x) + 1'b1) : $unsigned(delta_x);

	assign oct_in.steep = (ay > ax);
	assign oct_in.neg_x = delta_x[IN_WIDTH-1];
	assign oct_in.neg_y = delta_y[IN_WIDTH-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mn_s1  <= oct_in.steep ? ax : ay;
			mx_s1  <= oct_in.steep ? ay : ax;
			oct_s1 <= oct_in;
		end
	end

	fa2d_div #(
		.IN_WIDTH(IN_WIDTH)
	) u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.vld_in  (vld_s1),
		.mn      (mn_s1),
		.mx      (mx_s1),
		.oct_in  (oct_s1),
		.vld_out (div_vld),
		.ratio   (div_c),
		.oct_out (div_oct)
	);

	fa2d_poly #(
		.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)
	) u_poly (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.vld_in    (div_vld),
		.ratio     (div_c),
		.oct_in    (div_oct),
		.vld_out   (poly_vld),
		.oct_angle (poly_a),
		.oct_out   (poly_oct)
	);

	assign u_steep = poly_oct.steep ? (DEG90 - poly_a) : poly_a;
	assign u_negx  = poly_oct.neg_x ? (DEG180 - u_steep) : u_steep;
	assign u_negy  = poly_oct.neg_y ? (DEG360 - u_negx) : u_negx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (en) begin
			rsp_valid_q <= poly_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			angle_q <= u_negy;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign angle     = angle_q;

	`AST_IMPLY(a_empty_out_no_stall, clk, arst_n, !rsp_valid, !req_stall)
	`AST_IMPLY(a_out_stall_freezes, clk, arst_n, rsp_valid && rsp_stall, req_stall)
	`AST_IMPLY(a_ratio_range, clk, arst_n, div_vld, div_c <= RATIO_ONE)
	`AST_NEVER(a_angle_range, clk, arst_n, rsp_valid && (angle > DEG360))

endmodule

// ----- tb/tb.sv -----
// Self-checking testbench for fast_atan2_degrees_core: vectors in, angles in degrees out.
// Predicts each angle in fixed point and checks it against the DUT under random idling.
// Depends on fast_atan2_degrees_core and the RTL it pulls in.
`timescale 1ns / 1ps

module tb;

	localparam longint POLY_C1 = 3754140;
	localparam longint POLY_C3 = -1223390;
	localparam longint POLY_C5 = 584188;
	localparam longint POLY_C7 = -166443;
	localparam longint DEG_90  = 90 << 8;
	localparam longint DEG_180 = 180 << 8;
	localparam longint DEG_360 = 360 << 8;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               req_valid = 1'b0;
	logic               req_stall;
	logic signed [15:0] delta_y = '0;
	logic signed [15:0] delta_x = '0;
	logic               rsp_valid;
	logic               rsp_stall = 1'b0;
	logic        [16:0] angle;

	logic [16:0] angle_q[$];
	int          mismatches = 0;
	bit          idle_on = 1'b1;
	logic        hold_active = 1'b0;
	int          stall_left = 0;

	fast_atan2_degrees_core #(
		.IN_WIDTH(16),
		.ANGLE_FRAC_BITS(8)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.delta_y(delta_y),
		.delta_x(delta_x),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.angle(angle)
	);

	initial forever #10 clk = ~clk;

	initial begin
		#2_000_000;
		$display("Test completed with failures");
		$finish;
	end

	// product brought back to 16 fractional bits, rounded half up
	function automatic longint q16_round(input longint p);
		return (p + 32768) >>> 16;
	endfunction

	function automatic logic [16:0] expected_angle(input logic signed [15:0] dy,
			input logic signed [15:0] dx);
		longint ay, ax, mn, mx, ratio, ratio2, acc, deg;
		bit     steep;
		ay = (dy < 0) ? -longint'(dy) : longint'(dy);
		ax = (dx < 0) ? -longint'(dx) : longint'(dx);
		steep = ay > ax;
		mn = steep ? ax : ay;
		mx = steep ? ay : ax;
		ratio = (mx != 0) ? (mn <<< 16) / mx : 0;
		ratio2 = q16_round(ratio * ratio);
		acc = q16_round(POLY_C7 * ratio2) + POLY_C5;
		acc = q16_round(acc * ratio2) + POLY_C3;
		acc = q16_round(acc * ratio2) + POLY_C1;
		deg = q16_round(acc * ratio);
		if (deg < 0)
			deg = 0;
		deg = (deg + 128) >>> 8;
		if (steep)
			deg = DEG_90 - deg;
		if (dx < 0)
			deg = DEG_180 - deg;
		if (dy < 0)
			deg = DEG_360 - deg;
		return deg[16:0];
	endfunction

	task automatic report_mismatch(input string what, input logic [16:0] exp_angle);
		if (mismatches < 10)
			$display("%0t: %s: expected angle %0d, got %0d", $realtime, what, exp_angle, angle);
		mismatches++;
	endtask

	// one beat on the request side; valid stays high into the next call unless it idles
	task automatic send_vector(input logic signed [15:0] dy, input logic signed [15:0] dx);
		int gap;
		if (idle_on && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 5);
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_valid <= 1'b1;
		delta_y <= dy;
		delta_x <= dx;
		do @(posedge clk); while (req_stall !== 1'b0);
		angle_q.push_back(expected_angle(dy, dx));
	endtask

	always @(posedge clk) begin
		if (hold_active) begin
			rsp_stall <= 1'b1;
		end else if (stall_left > 0) begin
			rsp_stall <= 1'b1;
			stall_left <= stall_left - 1;
		end else if (idle_on && $urandom_range(0, 5) == 0) begin
			rsp_stall <= 1'b1;
			stall_left <= $urandom_range(0, 4);
		end else begin
			rsp_stall <= 1'b0;
		end
	end

	always @(posedge clk) begin
		if (arst_n && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
			if (angle_q.size() == 0)
				report_mismatch("unexpected beat", 'x);
			else if (angle !== angle_q[0])
				report_mismatch("angle mismatch", angle_q.pop_front());
			else
				void'(angle_q.pop_front());
		end
	end

	function automatic logic signed [15:0] pick_component(input int mode);
		logic signed [15:0] v;
		case (mode)
			0: v = 16'($urandom);
			1: v = 16'(int'($urandom_range(0, 30)) - 15);
			2: v = 16'($urandom_range(0, 255));
			default: begin
				case ($urandom_range(0, 5))
					0: v = -16'sd32768;
					1: v = -16'sd32767;
					2: v = -16'sd1;
					3: v = 16'sd0;
					4: v = 16'sd1;
					default: v = 16'sd32767;
				endcase
			end
		endcase
		return v;
	endfunction

	task automatic test_directed();
		send_vector(0, 0);
		send_vector(0, 1);
		send_vector(1, 0);
		send_vector(0, -1);
		send_vector(-1, 0);
		send_vector(32767, 32767);
		send_vector(-32768, -32768);
		send_vector(-32768, 32767);
		send_vector(32767, -32768);
		send_vector(-32768, 0);
		send_vector(0, -32768);
		send_vector(-1, 32767);
		send_vector(-1, -32768);
		send_vector(1, -32768);
		send_vector(100, 100);
		send_vector(-100, 100);
		send_vector(100, -100);
		send_vector(-100, -100);
		send_vector(32767, 1);
		send_vector(-32767, -1);
		send_vector(5, 3);
		send_vector(-3, 5);
		send_vector(12345, -23456);
		send_vector(-21846, 10923);
	endtask

	task automatic test_random();
		logic signed [15:0] dy, dx;
		int                 mode;
		for (int i = 0; i < 260; i++) begin
			mode = $urandom_range(0, 4);
			if (mode == 4) begin
				// near a diagonal
				dx = 16'($urandom);
				dy = dx + 16'(int'($urandom_range(0, 4)) - 2);
				if ($urandom_range(0, 1))
					dy = -dy;
			end else begin
				dy = pick_component(mode == 3 ? $urandom_range(0, 3) : mode);
				dx = pick_component(mode == 3 ? $urandom_range(0, 3) : mode);
			end
			send_vector(dy, dx);
		end
	endtask

	task automatic test_backpressure();
		fork
			begin
				hold_active <= 1'b1;
				repeat (150) @(posedge clk);
				hold_active <= 1'b0;
			end
			for (int i = 0; i < 60; i++)
				send_vector(16'($urandom), 16'($urandom));
		join
	endtask

	task automatic test_no_idle();
		idle_on = 1'b0;
		for (int i = 0; i < 60; i++)
			send_vector(16'($urandom), 16'($urandom));
	endtask

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random();
		test_backpressure();
		test_no_idle();
		req_valid <= 1'b0;
		while (angle_q.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
		if (mismatches == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

// ----- sim.f -----
+incdir+rtl
rtl/fa2d_pkg.sv
rtl/fa2d_div.sv
rtl/fa2d_poly.sv
rtl/fast_atan2_degrees_core.sv
tb/tb.sv
